// ----- src/running_median_ping_filter_defines.svh -----
// running_median_ping_filter_defines.svh: assertion macros for the ping filter.
// No dependencies; pulled in by the top level by `include.
`ifndef RUNNING_MEDIAN_PING_FILTER_DEFINES_SVH
`define RUNNING_MEDIAN_PING_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RMPF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmpf: assertion failed");

// Next-cycle implication, disabled during reset.
`define RMPF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmpf: assertion failed");

`endif

// ----- src/rmpf_pkg.sv -----
// rmpf_pkg.sv: types and constants shared by the ping filter modules.
// No dependencies.
`default_nettype none

package rmpf_pkg;

   localparam int PING_W      = 9;
   localparam int CMD_W       = 2;
   localparam int SLOT_W      = 5;
   localparam int SAMPLE_W    = 16;
   localparam int FACTOR_W    = 4;
   localparam int RATE_W      = 10;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int PROD_W      = PING_W + FACTOR_W;

   // divider: DIV_W bit operands, DIV_STEP_BITS quotient bits per cycle
   localparam int DIV_W         = 10;
   localparam int DIV_STEP_BITS = 2;
   localparam int DIV_CYCLES    = DIV_W / DIV_STEP_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

   localparam logic [PING_W-1:0]   CAP_RESET    = 9'd500;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 4'd5;
   localparam logic [RATE_W-1:0]   RATE_RESET   = 10'd0;
   localparam logic [DIV_W-1:0]    MS_PER_SEC   = 10'd1000;

   localparam logic [CMD_W-1:0] CMD_OBSERVE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_PING_CAP       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUTLIER_FACTOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_EMIT_RATE      = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]           cmd;
      logic [SLOT_W-1:0]          slot;
      logic signed [SAMPLE_W-1:0] ping_sample;
   } req_type;

   typedef struct packed {
      logic              pushed;
      logic [PING_W-1:0] filtered_ping;
      logic [PING_W-1:0] back_shift;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_DELETE,
      CELL_INSERT,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [PING_W-1:0] key;
   } cell_ctl_type;

   typedef struct packed {
      logic              valid;
      logic [PING_W-1:0] value;
      logic              flag;
   } cell_port_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_INSERT,
      ST_JUDGE,
      ST_PERIOD,
      ST_SHIFT,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ----- src/rmpf_cell.sv -----
// rmpf_cell.sv: one cell of the sorted window chain.
// Depends on rmpf_pkg.
`default_nettype none

module rmpf_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  rmpf_pkg::cell_ctl_type ctl,
   input  rmpf_pkg::cell_port_type nbr_left,
   input  rmpf_pkg::cell_port_type nbr_right,
   output rmpf_pkg::cell_port_type cell_out
);

   logic                        valid_ff, valid_in;
   logic [rmpf_pkg::PING_W-1:0] value_ff, value_in;
   logic                        flag;

   // delete: this cell and all above it shift down by one
   // insert: first invalid-or-greater cell takes the key, the rest shift up
   always_comb begin
      case (ctl.op)
         rmpf_pkg::CELL_DELETE: flag = valid_ff && (value_ff >= ctl.key);
         rmpf_pkg::CELL_INSERT: flag = !valid_ff || (value_ff > ctl.key);
         default:               flag = 1'b0;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      case (ctl.op)
         rmpf_pkg::CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         rmpf_pkg::CELL_DELETE: begin
            if (flag) begin
               valid_in = nbr_right.valid;
               value_in = nbr_right.value;
            end
         end
         rmpf_pkg::CELL_INSERT: begin
            if (nbr_left.flag) begin
               valid_in = nbr_left.valid;
               value_in = nbr_left.value;
            end else if (flag) begin
               valid_in = 1'b1;
               value_in = ctl.key;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_out.valid = valid_ff;
   assign cell_out.value = value_ff;
   assign cell_out.flag  = flag;

endmodule

`default_nettype wire

// ----- src/rmpf_chain.sv -----
// rmpf_chain.sv: row of sorted cells holding the window, with rank readout.
// Depends on rmpf_pkg and rmpf_cell.
`default_nettype none

module rmpf_chain #(
   parameter int WINDOW = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  rmpf_pkg::cell_ctl_type       ctl,
   input  wire [$clog2(WINDOW)-1:0]     rank,
   output logic [rmpf_pkg::PING_W-1:0]  rank_value,
   output logic [WINDOW-1:0]            valid_vec
);

   rmpf_pkg::cell_port_type ports [WINDOW];

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      rmpf_pkg::cell_port_type lft, rgt;

      if (i == 0) begin : g_first
         assign lft = '0;
      end else begin : g_mid_l
         assign lft = ports[i-1];
      end

      if (i == WINDOW - 1) begin : g_last
         assign rgt = '0;
      end else begin : g_mid_r
         assign rgt = ports[i+1];
      end

      rmpf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .nbr_left  (lft),
         .nbr_right (rgt),
         .cell_out  (ports[i])
      );

      assign valid_vec[i] = ports[i].valid;
   end

   assign rank_value = ports[rank].value;

endmodule

`default_nettype wire

// ----- src/rmpf_div.sv -----
// rmpf_div.sv: iterative restoring divider, two quotient bits per cycle.
// Depends on rmpf_pkg.
`default_nettype none

module rmpf_div (
   input  wire                   clock,
   input  wire                   reset,
   input  rmpf_pkg::div_req_type req,
   output rmpf_pkg::div_rsp_type rsp
);

   localparam int W = rmpf_pkg::DIV_W;

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [rmpf_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [W-1:0]                    rem_ff, rem_in;
   logic [W-1:0]                    quo_ff, quo_in;
   logic [W-1:0]                    den_ff, den_in;
   logic [W-1:0]                    rem_step, quo_step;
   logic [W:0]                      trial;

   // dividend bits shift out of quo from the top, quotient bits enter below
   always_comb begin
      rem_step = rem_ff;
      quo_step = quo_ff;
      trial    = '0;
      for (int i = 0; i < rmpf_pkg::DIV_STEP_BITS; i++) begin
         trial    = {rem_step, quo_step[W-1]};
         quo_step = {quo_step[W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial       = trial - {1'b0, den_ff};
            quo_step[0] = 1'b1;
         end
         rem_step = trial[W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = rem_step;
         quo_in = quo_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rmpf_pkg::DIV_CNT_W'(rmpf_pkg::DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ----- src/running_median_ping_filter.sv -----
// Running median ping filter: per-slot ping de-duplication, a sliding window
// of the last WINDOW kept samples held sorted in a row of cells, and a query
// path that swaps implausible raw pings for the upper median and derives a
// back-shift in frames. Commands on req_payload.cmd: observe, query, clear
// (3 is ignored). Every word accepted yields exactly one rsp word. Words go
// through one at a time: a kept observe passes check, cell insert and
// response load; a dropped observe, a clear or the ignored code passes
// check and response load. A query passes check and response load when
// the slot is out of range, adds a judge step when emit_rate_hz is 0, and
// else adds judge and two passes through the shared 2-bit-per-cycle divider
// (frame period 1000/rate, then ping/period). The next word is accepted as
// soon as the previous one is loaded into the rsp register, even if it is
// still waiting there. CSR writes (csr_index 0 ping_cap, 1 outlier_factor,
// 2 emit_rate_hz) are always accepted; write them only while the
// block is idle.
`default_nettype none

`include "running_median_ping_filter_defines.svh"

module running_median_ping_filter #(
   parameter int WINDOW = 32,
   parameter int SLOTS  = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // request words
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  rmpf_pkg::req_type                   req_payload,
   // response words
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output rmpf_pkg::rsp_type                   rsp_payload,
   // register writes
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [rmpf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [rmpf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IDX_W   = $clog2(WINDOW);
   localparam int FILL_W  = $clog2(WINDOW + 1);
   localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW      = rmpf_pkg::PING_W;

   // control and config
   rmpf_pkg::state_type                  state_ff, state_in;
   logic [PW-1:0]                        cap_ff, cap_in;
   logic [rmpf_pkg::FACTOR_W-1:0]        factor_ff, factor_in;
   logic [rmpf_pkg::RATE_W-1:0]          rate_ff, rate_in;
   logic [FILL_W-1:0]                    fill_ff, fill_in;
   logic [IDX_W-1:0]                     cursor_ff, cursor_in;
   logic [SLOTS-1:0]                     slot_valid_ff, slot_valid_in;
   logic                                 rsp_valid_ff, rsp_valid_in;

   // payload registers
   rmpf_pkg::req_type                    item_ff, item_in;
   rmpf_pkg::rsp_type                    rsp_ff, rsp_in;
   logic                                 pushed_ff, pushed_in;
   logic [PW-1:0]                        med_ff, med_in;
   logic [PW-1:0]                        filt_ff, filt_in;
   logic [PW-1:0]                        shift_ff, shift_in;
   logic [PW-1:0]                        last_rd_ff;
   logic [PW-1:0]                        oldest_rd_ff;

   // memories: per-slot last kept ping, and the window in arrival order
   logic [PW-1:0]                        slot_ping_mem [SLOTS];
   logic [PW-1:0]                        ring_mem [WINDOW];

   logic                                 req_fire;
   logic                                 slot_we, ring_we;
   logic [SLOT_AW-1:0]                   req_slot_addr, item_slot_addr;
   logic                                 slot_ok, in_range, dup, keep, too_big;
   logic [PW-1:0]                        sample9;
   logic [rmpf_pkg::PROD_W-1:0]          prod;
   logic [rmpf_pkg::DIV_W-1:0]           period;
   logic                                 row_matches_fill;

   rmpf_pkg::cell_ctl_type               cell_ctl;
   logic [PW-1:0]                        rank_value;
   logic [WINDOW-1:0]                    chain_valid;
   rmpf_pkg::div_req_type                div_req;
   rmpf_pkg::div_rsp_type                div_rsp;

   rmpf_chain #(
      .WINDOW (WINDOW)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctl        (cell_ctl),
      .rank       (IDX_W'(fill_ff >> 1)),
      .rank_value (rank_value),
      .valid_vec  (chain_valid)
   );

   rmpf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_fire       = req_valid && req_ready;
   assign req_slot_addr  = SLOT_AW'(req_payload.slot);
   assign item_slot_addr = SLOT_AW'(item_ff.slot);
   assign csr_ready      = 1'b1;

   // sample checks on the held word
   assign slot_ok  = int'(item_ff.slot) < SLOTS;
   assign sample9  = item_ff.ping_sample[PW-1:0];
   assign in_range = !item_ff.ping_sample[rmpf_pkg::SAMPLE_W-1]
                     && (item_ff.ping_sample != '0)
                     && ({1'b0, item_ff.ping_sample[rmpf_pkg::SAMPLE_W-2:0]}
                         <= rmpf_pkg::SAMPLE_W'(cap_ff));
   assign dup      = slot_valid_ff[item_slot_addr] && (last_rd_ff == sample9);
   assign keep     = slot_ok && in_range && !dup;
   assign prod     = rmpf_pkg::PROD_W'(factor_ff) * rmpf_pkg::PROD_W'(med_ff);
   assign too_big  = (med_ff != '0) && (rmpf_pkg::PROD_W'(sample9) > prod);
   // 1000/rate is 0 only above 1000 Hz; period then clamps to 1 ms
   assign period   = (div_rsp.quotient == '0) ? rmpf_pkg::DIV_W'(1) : div_rsp.quotient;

   // config register writes
   always_comb begin
      cap_in    = cap_ff;
      factor_in = factor_ff;
      rate_in   = rate_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rmpf_pkg::REG_PING_CAP:       cap_in    = csr_wdata[PW-1:0];
            rmpf_pkg::REG_OUTLIER_FACTOR: factor_in = csr_wdata[rmpf_pkg::FACTOR_W-1:0];
            rmpf_pkg::REG_EMIT_RATE:      rate_in   = csr_wdata[rmpf_pkg::RATE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // main sequencer
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      cursor_in     = cursor_ff;
      slot_valid_in = slot_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      item_in       = item_ff;
      rsp_in        = rsp_ff;
      pushed_in     = pushed_ff;
      med_in        = med_ff;
      filt_in       = filt_ff;
      shift_in      = shift_ff;
      req_ready     = 1'b0;
      slot_we       = 1'b0;
      ring_we       = 1'b0;
      cell_ctl.op   = rmpf_pkg::CELL_HOLD;
      cell_ctl.key  = sample9;
      div_req.start    = 1'b0;
      div_req.dividend = rmpf_pkg::MS_PER_SEC;
      div_req.divisor  = rmpf_pkg::DIV_W'(rate_ff);

      // rsp register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         rmpf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               item_in   = req_payload;
               pushed_in = 1'b0;
               filt_in   = '0;
               shift_in  = '0;
               state_in  = rmpf_pkg::ST_CHECK;
            end
         end

         rmpf_pkg::ST_CHECK: begin
            state_in = rmpf_pkg::ST_RESP;
            case (item_ff.cmd)
               rmpf_pkg::CMD_OBSERVE: begin
                  if (keep) begin
                     pushed_in = 1'b1;
                     slot_we   = 1'b1;
                     ring_we   = 1'b1;
                     slot_valid_in[item_slot_addr] = 1'b1;
                     cursor_in = (cursor_ff == IDX_W'(WINDOW - 1)) ? '0 : cursor_ff + 1'b1;
                     // full window: drop the oldest value from the sorted row first
                     if (fill_ff == FILL_W'(WINDOW)) begin
                        cell_ctl.op  = rmpf_pkg::CELL_DELETE;
                        cell_ctl.key = oldest_rd_ff;
                     end else begin
                        fill_in = fill_ff + 1'b1;
                     end
                     state_in = rmpf_pkg::ST_INSERT;
                  end
               end
               rmpf_pkg::CMD_QUERY: begin
                  if (slot_ok) begin
                     // upper median: sorted entry at rank fill/2, empty gives 0
                     med_in   = (fill_ff == '0) ? '0 : rank_value;
                     state_in = rmpf_pkg::ST_JUDGE;
                  end
               end
               rmpf_pkg::CMD_CLEAR: begin
                  cell_ctl.op   = rmpf_pkg::CELL_CLEAR;
                  fill_in       = '0;
                  cursor_in     = '0;
                  slot_valid_in = '0;
               end
               default: begin
               end
            endcase
         end

         rmpf_pkg::ST_INSERT: begin
            cell_ctl.op  = rmpf_pkg::CELL_INSERT;
            cell_ctl.key = sample9;
            state_in     = rmpf_pkg::ST_RESP;
         end

         rmpf_pkg::ST_JUDGE: begin
            filt_in = (!in_range || too_big) ? med_ff : sample9;
            if (rate_ff == '0) begin
               state_in = rmpf_pkg::ST_RESP;
            end else begin
               div_req.start = 1'b1;
               state_in      = rmpf_pkg::ST_PERIOD;
            end
         end

         rmpf_pkg::ST_PERIOD: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = rmpf_pkg::DIV_W'(filt_ff);
               div_req.divisor  = period;
               state_in         = rmpf_pkg::ST_SHIFT;
            end
         end

         rmpf_pkg::ST_SHIFT: begin
            if (div_rsp.done) begin
               shift_in = div_rsp.quotient[PW-1:0];
               state_in = rmpf_pkg::ST_RESP;
            end
         end

         rmpf_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.pushed        = pushed_ff;
               rsp_in.filtered_ping = filt_ff;
               rsp_in.back_shift    = shift_ff;
               rsp_valid_in         = 1'b1;
               state_in             = rmpf_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rmpf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rmpf_pkg::ST_IDLE;
         cap_ff        <= rmpf_pkg::CAP_RESET;
         factor_ff     <= rmpf_pkg::FACTOR_RESET;
         rate_ff       <= rmpf_pkg::RATE_RESET;
         fill_ff       <= '0;
         cursor_ff     <= '0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         factor_ff     <= factor_in;
         rate_ff       <= rate_in;
         fill_ff       <= fill_in;
         cursor_ff     <= cursor_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      rsp_ff    <= rsp_in;
      pushed_ff <= pushed_in;
      med_ff    <= med_in;
      filt_ff   <= filt_in;
      shift_ff  <= shift_in;
   end

   // memory ports: reads launch on acceptance, writes land in the check cycle
   always_ff @(posedge clock) begin
      if (req_fire) begin
         last_rd_ff   <= slot_ping_mem[req_slot_addr];
         oldest_rd_ff <= ring_mem[cursor_ff];
      end
      if (slot_we) begin
         slot_ping_mem[item_slot_addr] <= sample9;
      end
      if (ring_we) begin
         ring_mem[cursor_ff] <= sample9;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign row_matches_fill = $countones(chain_valid) == int'(fill_ff);

   // fill count never passes the window size
   `RMPF_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, int'(fill_ff) <= WINDOW)
   // between words the sorted row holds exactly fill_count entries
   `RMPF_ASSERT_IMPL(a_idle_count, clock, reset, state_ff == rmpf_pkg::ST_IDLE, row_matches_fill)
   // an insert step leaves the row matching the fill count
   `RMPF_ASSERT_NEXT(a_insert_count, clock, reset, state_ff == rmpf_pkg::ST_INSERT, row_matches_fill)
   // divider is never left running once the block is idle
   `RMPF_ASSERT_IMPL(a_div_idle, clock, reset, state_ff == rmpf_pkg::ST_IDLE, !div_rsp.busy)

endmodule

`default_nettype wire

// ----- tb/running_median_ping_filter_checker.sv -----
// running_median_ping_filter_checker.sv: scoreboard for the ping filter. It watches the
// req, rsp and csr channels, keeps its own estimator and compares every rsp word.
// Depends on rmpf_pkg.
`timescale 1ns / 1ps

module running_median_ping_filter_checker
   import rmpf_pkg::*;
#(
   parameter int WINDOW = 32,
   parameter int SLOTS  = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire                    req_ready,
   input  req_type                req_payload,
   input  wire                    rsp_valid,
   input  wire                    rsp_ready,
   input  rsp_type                rsp_payload,
   input  wire                    csr_valid,
   input  wire                    csr_ready,
   input  wire [CSR_IDX_W-1:0]    csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_wdata,
   output int                     mismatch_count,
   output int                     words_in_flight
);

   logic [PING_W-1:0]   cap_reg;
   logic [FACTOR_W-1:0] factor_reg;
   logic [RATE_W-1:0]   rate_reg;

   logic [PING_W-1:0]   ring [WINDOW];
   int unsigned         ring_fill;
   int unsigned         ring_cursor;
   logic [PING_W-1:0]   slot_ping [SLOTS];
   logic                slot_seen [SLOTS];

   rsp_type             expected_rsp [$];
   int                  errors;

   function automatic void clear_estimator();
      int i;
      for (i = 0; i < WINDOW; i++) ring[i] = '0;
      for (i = 0; i < SLOTS; i++) begin
         slot_ping[i] = '0;
         slot_seen[i] = 1'b0;
      end
      ring_fill   = 0;
      ring_cursor = 0;
   endfunction

   // upper median of the filled entries; the ring fills from entry 0
   function automatic int unsigned ring_median();
      int unsigned sorted [WINDOW];
      int unsigned n;
      int unsigned v;
      int          i;
      int          j;
      n = ring_fill;
      if (n == 0) return 0;
      for (i = 0; i < n; i++) sorted[i] = ring[i];
      for (i = 1; i < n; i++) begin
         v = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = v;
      end
      return sorted[n/2];
   endfunction

   function automatic rsp_type predict_filter_word(input req_type w);
      rsp_type     r;
      int          ping;
      int unsigned med;
      int unsigned filt;
      int unsigned period;
      r    = '0;
      ping = $signed(w.ping_sample);
      case (w.cmd)
         CMD_OBSERVE: begin
            if (int'(w.slot) < SLOTS && ping > 0 && ping <= int'(cap_reg)) begin
               if (!(slot_seen[w.slot] && slot_ping[w.slot] == PING_W'(ping))) begin
                  slot_ping[w.slot]  = PING_W'(ping);
                  slot_seen[w.slot]  = 1'b1;
                  ring[ring_cursor]  = PING_W'(ping);
                  ring_cursor        = (ring_cursor + 1 >= WINDOW) ? 0 : ring_cursor + 1;
                  if (ring_fill < WINDOW) ring_fill++;
                  r.pushed = 1'b1;
               end
            end
         end
         CMD_QUERY: begin
            if (int'(w.slot) < SLOTS) begin
               med = ring_median();
               if (ping <= 0 || ping > int'(cap_reg) ||
                   (med > 0 && ping > int'(factor_reg) * int'(med)))
                  filt = med;
               else
                  filt = ping;
               r.filtered_ping = PING_W'(filt);
               if (rate_reg != 0) begin
                  period = 1000 / int'(rate_reg);
                  if (period == 0) period = 1;   // rates above 1000 Hz
                  r.back_shift = PING_W'(filt / period);
               end
            end
         end
         CMD_CLEAR: clear_estimator();
         default: ;
      endcase
      return r;
   endfunction

   function automatic void note_failure(input string what, input rsp_type want,
                                        input rsp_type got);
      errors++;
      if (errors <= 10)
         $display("%0t rsp %s: expected pushed %0d filt %0d shift %0d, got pushed %0d filt %0d shift %0d",
                  $realtime, what, want.pushed, want.filtered_ping, want.back_shift,
                  got.pushed, got.filtered_ping, got.back_shift);
   endfunction

   initial begin
      errors          = 0;
      mismatch_count  = 0;
      words_in_flight = 0;
   end

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         cap_reg    = CAP_RESET;
         factor_reg = FACTOR_RESET;
         rate_reg   = RATE_RESET;
         clear_estimator();
         expected_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PING_CAP:       cap_reg    = csr_wdata[PING_W-1:0];
               REG_OUTLIER_FACTOR: factor_reg = csr_wdata[FACTOR_W-1:0];
               REG_EMIT_RATE:      rate_reg   = csr_wdata[RATE_W-1:0];
               default: ;
            endcase
         end
         // rsp first: a word accepted this edge cannot answer the req accepted with it
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               note_failure("with nothing expected", '0, rsp_payload);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_payload.pushed !== want.pushed ||
                   rsp_payload.filtered_ping !== want.filtered_ping ||
                   rsp_payload.back_shift !== want.back_shift)
                  note_failure("mismatch", want, rsp_payload);
            end
         end
         if (req_valid && req_ready)
            expected_rsp.push_back(predict_filter_word(req_payload));
      end
      mismatch_count  <= errors;
      words_in_flight <= expected_rsp.size();
   end

endmodule

// ----- tb/running_median_ping_filter_tb.sv -----
// running_median_ping_filter_tb.sv: top of the ping filter testbench. Makes clock, reset,
// req words, rsp back-pressure and csr writes, and gives the verdict.
// Depends on rmpf_pkg, running_median_ping_filter and running_median_ping_filter_checker.
`timescale 1ns / 1ps

module running_median_ping_filter_tb;
   import rmpf_pkg::*;

   // cmd code 3 is not a command; the block must answer it with an all-zero word
   localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 116;
   localparam int QUIET_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int                    mismatch_count;
   int                    words_in_flight;

   // sender burst state, receiver stall pattern, watchdog
   int unsigned           burst_left = 0;
   int unsigned           sink_left = 0;
   int unsigned           sink_mode = 0;
   int unsigned           quiet_cycles = 0;
   int unsigned           cur_cap = 500;   // ping_cap as last written, steers sample ranges

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   running_median_ping_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   running_median_ping_filter_checker filter_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .words_in_flight (words_in_flight)
   );

   // Receiver: runs of always-ready, of coin-flip ready and of hard stall, each of
   // random length, so stalls hold words in the rsp register and the response step.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_left = 0;
      end else begin
         if (sink_left == 0) begin
            sink_mode = $urandom_range(2);
            case (sink_mode)
               0:       sink_left = $urandom_range(20, 80);
               1:       sink_left = $urandom_range(10, 40);
               default: sink_left = $urandom_range(1, 12);
            endcase
         end
         sink_left--;
         case (sink_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(1));
            default: rsp_ready <= 1'b0;
         endcase
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("running_median_ping_filter_tb failed");
         $finish;
      end
   end

   function automatic req_type ping_word(input logic [CMD_W-1:0] cmd,
                                         input logic [SLOT_W-1:0] slot, input int ping);
      req_type w;
      w.cmd         = cmd;
      w.slot        = slot;
      w.ping_sample = ping[SAMPLE_W-1:0];
      return w;
   endfunction

   // Mostly plausible observe/query traffic, rare clear and ignored words, a slice
   // of garbage samples, cap-edge values and a small slot/value pool so repeats get dropped.
   function automatic req_type random_ping_word();
      req_type     w;
      int unsigned pick;
      int unsigned lim;
      int          ping;
      lim  = (cur_cap == 0) ? 1 : cur_cap;
      pick = $urandom_range(99);
      w.slot = SLOT_W'($urandom_range(31));
      if (pick < 1)       w.cmd = CMD_CLEAR;
      else if (pick < 3)  w.cmd = CMD_IGNORED;
      else if (pick < 62) w.cmd = CMD_OBSERVE;
      else                w.cmd = CMD_QUERY;
      pick = $urandom_range(99);
      if (pick < 12) begin
         ping = $urandom_range(65535);
      end else if (pick < 24) begin
         case ($urandom_range(4))
            0:       ping = 0;
            1:       ping = -1;
            2:       ping = cur_cap;
            3:       ping = cur_cap + 1;
            default: ping = 1;
         endcase
      end else if (pick < 50) begin
         ping = $urandom_range(1, 6);
         if (w.cmd == CMD_OBSERVE) w.slot = SLOT_W'($urandom_range(3));
      end else if (w.cmd == CMD_QUERY && pick < 65) begin
         ping = $urandom_range(1, 511);
      end else begin
         ping = $urandom_range(1, lim);
      end
      w.ping_sample = ping[SAMPLE_W-1:0];
      return w;
   endfunction

   // Sender: bursts of random length; between bursts valid drops for a random gap
   // (sometimes none). Besides wait_idle, valid is only lowered here, a step before it rises.
   task automatic send_word(input req_type w);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_payload <= w;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Park the sender and wait until every rsp word has come back. The first edge
   // lets the checker count the word accepted just before.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_settings(input logic [CSR_DATA_W-1:0] cap,
                                 input logic [CSR_DATA_W-1:0] factor,
                                 input logic [CSR_DATA_W-1:0] rate);
      write_reg(REG_PING_CAP, cap);
      write_reg(REG_OUTLIER_FACTOR, factor);
      write_reg(REG_EMIT_RATE, rate);
      csr_valid <= 1'b0;
      cur_cap = cap[PING_W-1:0];
   endtask

   initial begin : stimulus
      int                    ph;
      int                    n;
      logic [CSR_DATA_W-1:0] cap;
      logic [CSR_DATA_W-1:0] factor;
      logic [CSR_DATA_W-1:0] rate;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed words at reset settings: cap 500, factor 5, rate 0.
      // Empty ring: plausible ping passes, implausible ones give median 0.
      send_word(ping_word(CMD_QUERY, 5'd0, 100));
      send_word(ping_word(CMD_QUERY, 5'd5, 0));
      send_word(ping_word(CMD_QUERY, 5'd31, -32768));
      send_word(ping_word(CMD_QUERY, 5'd1, 32767));
      // observe: keep, repeat drop, non-positive drops, above-cap drop, cap edge
      send_word(ping_word(CMD_OBSERVE, 5'd0, 100));
      send_word(ping_word(CMD_OBSERVE, 5'd0, 100));
      send_word(ping_word(CMD_OBSERVE, 5'd0, 0));
      send_word(ping_word(CMD_OBSERVE, 5'd0, -1));
      send_word(ping_word(CMD_OBSERVE, 5'd7, 501));
      send_word(ping_word(CMD_OBSERVE, 5'd7, 500));
      send_word(ping_word(CMD_OBSERVE, 5'd31, 1));
      send_word(ping_word(CMD_OBSERVE, 5'd31, 32767));
      send_word(ping_word(CMD_OBSERVE, 5'd16, -32768));
      send_word(ping_word(CMD_OBSERVE, 5'd0, 200));
      // ring now holds 100 500 1 200: upper median 200
      send_word(ping_word(CMD_QUERY, 5'd2, 600));
      send_word(ping_word(CMD_QUERY, 5'd2, 450));
      // unused command code, with extreme slot and sample values
      send_word(ping_word(CMD_IGNORED, 5'd31, 32767));
      send_word(ping_word(CMD_IGNORED, 5'd0, -1));
      // clear drops ring and per-slot history
      send_word(ping_word(CMD_CLEAR, 5'd0, 0));
      send_word(ping_word(CMD_QUERY, 5'd3, 250));
      send_word(ping_word(CMD_OBSERVE, 5'd0, 100));

      // Random phases, each under its own register settings. Early phases pin
      // the extremes: rate 1000 (period 1) and 1023 (period clamp), rate 1, cap 0 (nothing
      // kept), factor 0 (any raw ping is an outlier once a median exists).
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin cap = 10'd500; factor = 10'd5;  rate = 10'd1000; end
            1: begin cap = 10'd1;   factor = 10'd0;  rate = 10'd1023; end
            2: begin cap = 10'h3FF; factor = 10'h3FF; rate = 10'd1;   end
            3: begin cap = 10'd0;   factor = 10'd3;  rate = 10'd60;   end
            4: begin cap = 10'd200; factor = 10'd1;  rate = 10'd0;    end
            default: begin
               cap    = CSR_DATA_W'($urandom_range(1, 511));
               factor = CSR_DATA_W'($urandom_range(15));
               rate   = CSR_DATA_W'($urandom_range(1023));
            end
         endcase
         wait_idle();
         write_settings(cap, factor, rate);
         for (n = 0; n < WORDS_PER_PHASE; n++) send_word(random_ping_word());
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && words_in_flight == 0)
         $display("running_median_ping_filter_tb passed");
      else
         $display("running_median_ping_filter_tb failed");
      $finish;
   end

endmodule
